>>> rtl/swm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window median package
// Widths, register map and the link type shared between the sorted cells.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int DATA_W     = 32;
    localparam int SIZE_W     = 5;
    localparam int WINDOW_DEF = 16;
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_IDX_W  = PADDR_W - 2;

    localparam logic [SIZE_W-1:0]    ACTIVE_SIZE_RESET = SIZE_W'(16);
    localparam logic [REG_IDX_W-1:0] REG_ACTIVE_SIZE   = '0;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              le_old;
        logic              le_new;
    } cell_link_t;

endpackage

>>> rtl/swm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted window cell
// One entry of the ascending sorted store. On each transfer the cell keeps
// its value, takes a neighbour's value or takes the new sample, so that the
// row drops the leaving sample and inserts the new one in the same transfer.
// ----------------------------------------------------------------------------
module swm_cell
    import swm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift_en,
    input  logic              new_ge_old,
    input  logic [DATA_W-1:0] old_val,
    input  logic [DATA_W-1:0] new_val,
    input  cell_link_t        prev_link,
    input  cell_link_t        next_link,
    output cell_link_t        link,
    input  logic              sel_lo,
    input  logic              sel_hi,
    output logic [DATA_W-1:0] lo_tap,
    output logic [DATA_W-1:0] hi_tap
);

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;

    assign link.value  = value_reg;
    assign link.le_old = (value_reg <= old_val);
    assign link.le_new = (value_reg <= new_val);

    assign lo_tap = sel_lo ? value_reg : '0;
    assign hi_tap = sel_hi ? value_reg : '0;

    always_comb
    begin
        if (new_ge_old)
        begin
            priority if (next_link.le_old)
                value_next = value_reg;
            else if (!link.le_new)
                value_next = value_reg;
            else if (!next_link.le_new)
                value_next = new_val;
            else
                value_next = next_link.value;
        end
        else
        begin
            priority if (link.le_new)
                value_next = value_reg;
            else if (!link.le_old)
                value_next = value_reg;
            else if (prev_link.le_new)
                value_next = new_val;
            else
                value_next = prev_link.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            value_reg <= '0;
        else if (shift_en)
            value_reg <= value_next;
    end

endmodule

>>> rtl/sliding_window_median_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window median filter
// Running median over the last WINDOW samples, with an APB register that
// sets the active size, from which the median position is taken.
// ----------------------------------------------------------------------------
// The filter takes one sample per clock, and returns one median per sample,
// while each median is taken when offered. A sample transfer updates a row
// of WINDOW sorted cells in that same cycle; calc_reg then marks the median
// due and it is registered in median_reg once the previous one is taken. The
// single compare-and-shift step inside each cell sets this rate. While a
// median waits to be taken, one further sample may already be accepted and
// sorted. After reset the window holds zeros and active_size is 16.
module sliding_window_median_top
    import swm_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic [DATA_W-1:0]     sample,
    input  logic                  sample_valid,
    output logic                  sample_ready,
    output logic [DATA_W-1:0]     median,
    output logic                  median_valid,
    input  logic                  median_ready
);

    localparam int IW = $clog2(WINDOW);
    localparam int DW = $clog2(WINDOW + 1);
    localparam int CW = (DW > SIZE_W) ? DW : SIZE_W;

    logic [SIZE_W-1:0]    active_size_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;

    logic [DATA_W-1:0] hist_reg [WINDOW];
    logic [DATA_W-1:0] oldest;
    logic              accept;
    logic              new_ge_old;

    cell_link_t        cell_link [WINDOW];
    logic [DATA_W-1:0] lo_taps   [WINDOW];
    logic [DATA_W-1:0] hi_taps   [WINDOW];
    logic [WINDOW-1:0] sel_lo;
    logic [WINDOW-1:0] sel_hi;

    logic [CW-1:0]     size_ext;
    logic [CW-1:0]     size_clamped;
    logic [CW-1:0]     rank;
    logic [IW-1:0]     lo_idx;
    logic [IW-1:0]     hi_idx;

    logic [DATA_W-1:0] lo_val;
    logic [DATA_W-1:0] hi_val;
    logic [DATA_W:0]   pair_sum;
    logic [DATA_W-1:0] median_next;

    logic              calc_reg;
    logic              median_valid_reg;
    logic [DATA_W-1:0] median_reg;
    logic              out_load;

    // Configuration port.
    assign pready    = 1'b1;
    assign reg_idx   = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (reg_idx == REG_ACTIVE_SIZE)
                     ? {{(APB_DATA_W-SIZE_W){1'b0}}, active_size_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_size_reg <= ACTIVE_SIZE_RESET;
        else if (cfg_write && (reg_idx == REG_ACTIVE_SIZE))
            active_size_reg <= pwdata[SIZE_W-1:0];
    end

    // Handshake and control.
    assign out_load     = calc_reg && (!median_valid_reg || median_ready);
    assign sample_ready = !calc_reg || !median_valid_reg || median_ready;
    assign accept       = sample_valid && sample_ready;
    assign median       = median_reg;
    assign median_valid = median_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calc_reg         <= 1'b0;
            median_valid_reg <= 1'b0;
        end
        else
        begin
            calc_reg <= accept || (calc_reg && !out_load);
            if (out_load)
                median_valid_reg <= 1'b1;
            else if (median_ready)
                median_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            median_reg <= median_next;
    end

    // Arrival order: the oldest sample leaves at the tail.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
                hist_reg[i] <= '0;
        end
        else if (accept)
        begin
            hist_reg[0] <= sample;
            for (int i = 1; i < WINDOW; i++)
                hist_reg[i] <= hist_reg[i-1];
        end
    end

    assign oldest     = hist_reg[WINDOW-1];
    assign new_ge_old = (sample >= oldest);

    // Median position from the active size.
    assign size_ext     = CW'(active_size_reg);
    assign size_clamped = (size_ext == '0) ? CW'(1)
                        : (size_ext > CW'(WINDOW)) ? CW'(WINDOW) : size_ext;
    assign rank         = size_clamped >> 1;
    assign lo_idx       = IW'(WINDOW - 1) - rank[IW-1:0];
    assign hi_idx       = lo_idx + IW'(1);

    // Sorted cell row.
    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        cell_link_t prev_l;
        cell_link_t next_l;

        if (i == 0)
        begin : g_first
            assign prev_l = '{value: '0, le_old: 1'b1, le_new: 1'b1};
        end
        else
        begin : g_prev
            assign prev_l = cell_link[i-1];
        end

        if (i == WINDOW - 1)
        begin : g_last
            assign next_l = '{value: '0, le_old: 1'b0, le_new: 1'b0};
        end
        else
        begin : g_next
            assign next_l = cell_link[i+1];
        end

        assign sel_lo[i] = (lo_idx == IW'(i));
        assign sel_hi[i] = (hi_idx == IW'(i));

        swm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_en   (accept),
            .new_ge_old (new_ge_old),
            .old_val    (oldest),
            .new_val    (sample),
            .prev_link  (prev_l),
            .next_link  (next_l),
            .link       (cell_link[i]),
            .sel_lo     (sel_lo[i]),
            .sel_hi     (sel_hi[i]),
            .lo_tap     (lo_taps[i]),
            .hi_tap     (hi_taps[i])
        );
    end

    always_comb
    begin
        lo_val = '0;
        hi_val = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            lo_val = lo_val | lo_taps[i];
            hi_val = hi_val | hi_taps[i];
        end
    end

    assign pair_sum    = {1'b0, lo_val} + {1'b0, hi_val};
    assign median_next = size_clamped[0] ? lo_val : pair_sum[DATA_W:1];

endmodule

>>> rtl/swm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window median port checker
// Concurrent checks on the ports of the filter, bound to the top level.
// ----------------------------------------------------------------------------
module swm_checker
    import swm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [PADDR_W-1:0]    paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata,
    input logic                  pready,
    input logic                  sample_valid,
    input logic                  sample_ready,
    input logic [DATA_W-1:0]     median,
    input logic                  median_valid,
    input logic                  median_ready
);

    a_median_hold: assert property (@(posedge clk) disable iff (!rst_n)
        median_valid && !median_ready |=> median_valid && $stable(median))
        else $error("median changed or dropped before its transfer");

    a_median_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(median_valid) |-> $past(sample_valid && sample_ready, 2))
        else $error("median offered without a sample transfer two cycles earlier");

    a_ready_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !median_valid |-> sample_ready)
        else $error("sample refused while the output is empty");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_ACTIVE_SIZE)
        |=> (paddr[PADDR_W-1:2] != REG_ACTIVE_SIZE)
            || (prdata[SIZE_W-1:0] == $past(pwdata[SIZE_W-1:0])))
        else $error("active size does not read back the written value");

endmodule

bind sliding_window_median_top swm_checker u_swm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .median       (median),
    .median_valid (median_valid),
    .median_ready (median_ready)
);
